// File: design/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants for the per-axis position step ramp.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

    // Speed table geometry.
    localparam int AXIS_DEPTH = 16;
    localparam int AXIS_IDX_W = $clog2(AXIS_DEPTH);

    // Field widths.
    localparam int SPEED_W = 16;
    localparam int POS_W   = 32;
    localparam int MNUM_W  = 4;
    localparam int ZONE_W  = 8;
    localparam int STAT_W  = 2;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 208;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = STAT_W;

    // Default axes per device group.
    localparam int DEF_MOTORS_PER_GROUP = 8;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_MOVING  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ARRIVED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

    // One unpacked input beat.
    typedef struct packed {
        logic                     group_sel;
        logic [MNUM_W-1:0]        motor_number;
        logic [MNUM_W-1:0]        motor_count;
        logic signed [POS_W-1:0]  current_pos;
        logic signed [POS_W-1:0]  aim_pos;
        logic [SPEED_W-1:0]       max_step;
        logic [SPEED_W-1:0]       arrive_threshold;
        logic signed [POS_W-1:0]  max_pos;
        logic signed [POS_W-1:0]  min_pos;
        logic [SPEED_W-1:0]       accel;
        logic [SPEED_W-1:0]       min_speed;
        logic [ZONE_W-1:0]        zone_factor;
    } t_item;

    // Decoded item held in the update stage while the speed is read.
    typedef struct packed {
        logic [AXIS_IDX_W-1:0]    idx;
        logic                     motor_ok;
        logic                     arrived;
        logic                     far;
        logic                     in_zone;
        logic                     pos_dir;
        logic signed [POS_W-1:0]  current_pos;
        logic signed [POS_W-1:0]  max_pos;
        logic signed [POS_W-1:0]  min_pos;
        logic [SPEED_W-1:0]       max_step;
        logic [SPEED_W-1:0]       accel;
        logic [SPEED_W-1:0]       min_speed;
    } t_stage;

endpackage

`default_nettype wire

// File: design/axis_position_step_ramp.sv
// ----------------------------------------------------------------------------
// axis_position_step_ramp
// Per-axis trapezoidal position stepper with a speed table per axis.
//
//   Channel  Dir  tdata (low bit up)                          tuser
//   s_axis   in   motor_number, motor_count, current_pos,     group_sel
//                 aim_pos, max_step, arrive_threshold,
//                 max_pos, min_pos, accel, min_speed,
//                 zone_factor (208 bits)
//   m_axis   out  target_pos (32 bits)                        status
//
// One beat is accepted per cycle while the output is not stalled. A beat is
// decoded and its axis speed read from the table on acceptance, updated in the
// update stage and written back as it hands its result to the output register.
// A same-axis write is forwarded into the read, so consecutive beats for one
// axis need no bubble. Reset clears the table valid bits at once; no sweep.
// A stalled output holds the update stage, which in turn deasserts tready.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_position_step_ramp #(
    parameter int MOTORS_PER_GROUP = spr_pkg::DEF_MOTORS_PER_GROUP
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // motor_number, motor_count, current_pos, aim_pos, max_step,
    // arrive_threshold, max_pos, min_pos, accel, min_speed, zone_factor
    input  logic [spr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // group_sel
    input  logic [spr_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // target_pos
    output logic [spr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // status
    output logic [spr_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);
    import spr_pkg::*;

    t_item              in_item;
    t_stage             n_stage;
    t_stage             r_stage;
    logic               r_stage_valid;
    logic               stage_adv;
    logic               in_accept;
    logic               wr_en;
    logic               upd_wr_en;
    logic [SPEED_W-1:0] old_speed;
    logic [SPEED_W-1:0] new_speed;
    logic [STAT_W-1:0]  n_status;
    logic [POS_W-1:0]   n_target;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_out_status;
    logic [POS_W-1:0]   r_out_target;

    // Unpack the input beat.
    always_comb begin
        in_item.group_sel        = s_axis_tuser[0];
        in_item.motor_number     = s_axis_tdata[3:0];
        in_item.motor_count      = s_axis_tdata[7:4];
        in_item.current_pos      = s_axis_tdata[39:8];
        in_item.aim_pos          = s_axis_tdata[71:40];
        in_item.max_step         = s_axis_tdata[87:72];
        in_item.arrive_threshold = s_axis_tdata[103:88];
        in_item.max_pos          = s_axis_tdata[135:104];
        in_item.min_pos          = s_axis_tdata[167:136];
        in_item.accel            = s_axis_tdata[183:168];
        in_item.min_speed        = s_axis_tdata[199:184];
        in_item.zone_factor      = s_axis_tdata[207:200];
    end

    // Handshake: the update stage moves whenever the output register frees.
    assign stage_adv     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_stage_valid || stage_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    spr_decode #(
        .MOTORS_PER_GROUP (MOTORS_PER_GROUP)
    ) u_decode (
        .i_item  (in_item),
        .o_stage (n_stage)
    );

    spr_speed_mem u_speed_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_accept),
        .i_rd_idx   (n_stage.idx),
        .i_wr_en    (wr_en),
        .i_wr_idx   (r_stage.idx),
        .i_wr_speed (new_speed),
        .o_rd_speed (old_speed)
    );

    spr_update u_update (
        .i_stage     (r_stage),
        .i_old_speed (old_speed),
        .o_wr_en     (upd_wr_en),
        .o_new_speed (new_speed),
        .o_status    (n_status),
        .o_target    (n_target)
    );

    // Write back only when the stage hands its result on.
    assign wr_en = r_stage_valid && stage_adv && upd_wr_en;

    // Update stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
        end else if (stage_adv || !r_stage_valid) begin
            r_stage_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_stage <= n_stage;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_adv) begin
            r_out_valid <= r_stage_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv && r_stage_valid) begin
            r_out_status <= n_status;
            r_out_target <= n_target;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_target;
    assign m_axis_tuser  = r_out_status;

    // An accepted beat always lands in the update stage.
    a_accept_lands : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_stage_valid)
        else $error("accepted beat did not reach the update stage");

    // A stalled update stage keeps its axis.
    a_stage_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage_valid && !stage_adv) |=> (r_stage_valid && $stable(r_stage.idx)))
        else $error("update stage lost its beat during a stall");

    // The written speed never exceeds the top speed of its beat.
    a_speed_capped : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (new_speed <= r_stage.max_step))
        else $error("speed written above max_step");

    // Arrived and invalid results carry a zero target.
    a_zero_target : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == STAT_ARRIVED || r_out_status == STAT_INVALID))
        |-> (r_out_target == '0))
        else $error("non-moving result with a nonzero target");

endmodule

`default_nettype wire

// File: design/spr_speed_mem.sv
// ----------------------------------------------------------------------------
// spr_speed_mem
// Per-axis speed table: one write port and one registered read port, with
// per-entry valid bits so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_speed_mem (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [spr_pkg::AXIS_IDX_W-1:0] i_rd_idx,
    input  logic                           i_wr_en,
    input  logic [spr_pkg::AXIS_IDX_W-1:0] i_wr_idx,
    input  logic [spr_pkg::SPEED_W-1:0]    i_wr_speed,
    output logic [spr_pkg::SPEED_W-1:0]    o_rd_speed
);
    import spr_pkg::*;

    logic [SPEED_W-1:0]    r_mem [AXIS_DEPTH];
    logic [AXIS_DEPTH-1:0] r_written;
    logic [SPEED_W-1:0]    r_rd_speed;

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_speed;
        end
    end

    // Valid bits: cleared by reset, set by the first write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr_en) begin
            r_written[i_wr_idx] <= 1'b1;
        end
    end

    // Registered read. A write to the same entry in the same cycle is
    // forwarded so that back-to-back beats for one axis see the new speed.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_idx == i_rd_idx)) begin
                r_rd_speed <= i_wr_speed;
            end else if (r_written[i_rd_idx]) begin
                r_rd_speed <= r_mem[i_rd_idx];
            end else begin
                r_rd_speed <= '0;
            end
        end
    end

    assign o_rd_speed = r_rd_speed;

endmodule

`default_nettype wire

// File: design/spr_decode.sv
// ----------------------------------------------------------------------------
// spr_decode
// Input decode: axis index, motor check, distance to aim and the arrival,
// approach and deceleration zone tests.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_decode #(
    parameter int MOTORS_PER_GROUP = spr_pkg::DEF_MOTORS_PER_GROUP
) (
    input  spr_pkg::t_item  i_item,
    output spr_pkg::t_stage o_stage
);
    import spr_pkg::*;

    localparam int SUM_W = $clog2(MOTORS_PER_GROUP + AXIS_DEPTH);

    logic [SUM_W-1:0]             grp_base;
    logic [SUM_W-1:0]             idx_sum;
    logic signed [POS_W:0]        diff;
    logic [POS_W:0]               adiff;
    logic [POS_W+2:0]             adiff_x5;
    logic [SPEED_W+2:0]           thr_x6;
    logic [SPEED_W+ZONE_W-1:0]    zone_lim;

    // Axis index, wrapped onto the table depth.
    assign grp_base = i_item.group_sel ? SUM_W'(MOTORS_PER_GROUP) : '0;
    assign idx_sum  = grp_base + SUM_W'(i_item.motor_number) - SUM_W'(1);

    // Distance to aim, one bit wider so it cannot wrap.
    assign diff  = {i_item.aim_pos[POS_W-1], i_item.aim_pos}
                 - {i_item.current_pos[POS_W-1], i_item.current_pos};
    assign adiff = diff[POS_W] ? (POS_W+1)'(-diff) : (POS_W+1)'(diff);

    // Arrival within 1.2 thresholds, done as 5*|d| < 6*thr.
    assign adiff_x5 = {adiff, 2'b00} + (POS_W+3)'(adiff);
    assign thr_x6   = {1'b0, i_item.arrive_threshold, 2'b00}
                    + {2'b00, i_item.arrive_threshold, 1'b0};

    // Deceleration zone limit.
    assign zone_lim = i_item.zone_factor * i_item.max_step;

    always_comb begin
        o_stage.idx         = idx_sum[AXIS_IDX_W-1:0];
        o_stage.motor_ok    = (i_item.motor_number != '0)
                            && (i_item.motor_number <= i_item.motor_count);
        o_stage.arrived     = adiff_x5 < (POS_W+3)'(thr_x6);
        o_stage.far         = adiff >= (POS_W+1)'(i_item.max_step);
        o_stage.in_zone     = adiff < (POS_W+1)'(zone_lim);
        o_stage.pos_dir     = !diff[POS_W] && (diff != '0);
        o_stage.current_pos = i_item.current_pos;
        o_stage.max_pos     = i_item.max_pos;
        o_stage.min_pos     = i_item.min_pos;
        o_stage.max_step    = i_item.max_step;
        o_stage.accel       = i_item.accel;
        o_stage.min_speed   = i_item.min_speed;
    end

endmodule

`default_nettype wire

// File: design/spr_update.sv
// ----------------------------------------------------------------------------
// spr_update
// Speed ramp and target step: turns the stored speed of an axis into its
// new speed, the result status and the clamped next target.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_update (
    input  spr_pkg::t_stage             i_stage,
    input  logic [spr_pkg::SPEED_W-1:0] i_old_speed,
    output logic                        o_wr_en,
    output logic [spr_pkg::SPEED_W-1:0] o_new_speed,
    output logic [spr_pkg::STAT_W-1:0]  o_status,
    output logic [spr_pkg::POS_W-1:0]   o_target
);
    import spr_pkg::*;

    logic signed [SPEED_W+1:0] dec_speed;
    logic [SPEED_W:0]          inc_speed;
    logic [SPEED_W:0]          ramp_speed;
    logic [SPEED_W-1:0]        step_speed;
    logic signed [POS_W+1:0]   step;
    logic signed [POS_W+1:0]   raw_target;
    logic signed [POS_W+1:0]   lim_hi;
    logic signed [POS_W+1:0]   lim_lo;
    logic signed [POS_W-1:0]   clamped;

    // Ramp down toward the floor, or up toward the top speed.
    assign dec_speed = $signed({2'b00, i_old_speed}) - $signed({2'b00, i_stage.accel});
    assign inc_speed = {1'b0, i_old_speed} + {1'b0, i_stage.accel};

    always_comb begin
        if (!i_stage.far) begin
            ramp_speed = {1'b0, i_stage.min_speed};
        end else if (i_stage.in_zone) begin
            if (dec_speed < $signed({2'b00, i_stage.min_speed})) begin
                ramp_speed = {1'b0, i_stage.min_speed};
            end else begin
                ramp_speed = dec_speed[SPEED_W:0];
            end
        end else if (inc_speed > {1'b0, i_stage.max_step}) begin
            ramp_speed = {1'b0, i_stage.max_step};
        end else begin
            ramp_speed = inc_speed;
        end
    end

    // Cap to the top speed; the value is never negative here.
    assign step_speed = (ramp_speed > {1'b0, i_stage.max_step})
                      ? i_stage.max_step : ramp_speed[SPEED_W-1:0];

    // Step toward the aim, then clamp to the travel limits (upper first).
    assign step       = i_stage.pos_dir ? $signed({18'd0, step_speed})
                                        : -$signed({18'd0, step_speed});
    assign raw_target = (POS_W+2)'(i_stage.current_pos) + step;
    assign lim_hi     = (POS_W+2)'(i_stage.max_pos);
    assign lim_lo     = (POS_W+2)'(i_stage.min_pos);

    always_comb begin
        if (raw_target >= lim_hi) begin
            clamped = i_stage.max_pos;
        end else if (raw_target <= lim_lo) begin
            clamped = i_stage.min_pos;
        end else begin
            clamped = raw_target[POS_W-1:0];
        end
    end

    // Result and table write-back.
    always_comb begin
        o_wr_en = i_stage.motor_ok;
        if (!i_stage.motor_ok) begin
            o_status    = STAT_INVALID;
            o_target    = '0;
            o_new_speed = '0;
        end else if (i_stage.arrived) begin
            o_status    = STAT_ARRIVED;
            o_target    = '0;
            o_new_speed = '0;
        end else begin
            o_status    = STAT_MOVING;
            o_target    = clamped;
            o_new_speed = step_speed;
        end
    end

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the per-axis position step ramp. Input beats carry
// directed corner cases, then closed-loop moves in which each new current
// position is the target that was just predicted, mixed with random noise
// beats. A scoreboard keeps its own per-axis speed table, predicts each
// result and compares the status and target fields of every output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;

    import spr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_TARGET = 450;

    // Scoreboard: per-axis speed prediction and in-order result checking.
    class step_ramp_scoreboard;
        logic [SPEED_W-1:0]     axis_speed[AXIS_DEPTH];
        logic [STAT_W-1:0]      status_q[$];
        logic signed [POS_W-1:0] target_q[$];
        int                     errors;

        function new();
            foreach (axis_speed[i]) axis_speed[i] = '0;
            errors = 0;
        endfunction

        // Work out the result of one accepted beat and queue it.
        function void note_tick(input t_item it, output logic [STAT_W-1:0] st,
                                output logic signed [POS_W-1:0] tgt);
            longint diff, adiff, spd, wide, mstep;
            int     idx;
            st    = STAT_MOVING;
            tgt   = '0;
            mstep = longint'(it.max_step);
            if (it.motor_number == 0 || it.motor_number > it.motor_count) begin
                st = STAT_INVALID;
            end else begin
                idx   = (int'(it.group_sel) * DEF_MOTORS_PER_GROUP
                         + int'(it.motor_number) - 1) % AXIS_DEPTH;
                diff  = longint'($signed(it.aim_pos)) - longint'($signed(it.current_pos));
                adiff = (diff < 0) ? -diff : diff;
                if (5 * adiff < 6 * longint'(it.arrive_threshold)) begin
                    axis_speed[idx] = '0;
                    st = STAT_ARRIVED;
                end else begin
                    spd = longint'(axis_speed[idx]);
                    if (adiff >= mstep) begin
                        if (adiff < longint'(it.zone_factor) * mstep) begin
                            spd = spd - longint'(it.accel);
                            if (spd < longint'(it.min_speed))
                                spd = longint'(it.min_speed);
                        end else begin
                            spd = spd + longint'(it.accel);
                            if (spd > mstep)
                                spd = mstep;
                        end
                    end else begin
                        spd = longint'(it.min_speed);
                    end
                    if (spd > mstep)
                        spd = mstep;
                    if (spd < 0)
                        spd = 0;
                    axis_speed[idx] = spd[SPEED_W-1:0];
                    // Step towards the aim; no positive difference steps down.
                    wide = longint'($signed(it.current_pos)) + ((diff > 0) ? spd : -spd);
                    if (wide >= longint'($signed(it.max_pos)))
                        wide = longint'($signed(it.max_pos));
                    else if (wide <= longint'($signed(it.min_pos)))
                        wide = longint'($signed(it.min_pos));
                    tgt = wide[POS_W-1:0];
                end
            end
            status_q.push_back(st);
            target_q.push_back(tgt);
        endfunction

        // Compare one output beat with the oldest expectation.
        function void check_result(logic [STAT_W-1:0] st, logic [POS_W-1:0] tgt);
            logic [STAT_W-1:0] e_st;
            logic [POS_W-1:0]  e_tgt;
            if (status_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: status %0d target %0d", st, $signed(tgt));
                return;
            end
            e_st  = status_q.pop_front();
            e_tgt = target_q.pop_front();
            if (st !== e_st || tgt !== e_tgt) begin
                errors++;
                if (errors <= 10)
                    $display("result differs: status exp %0d got %0d, target exp %0d got %0d",
                             e_st, st, $signed(e_tgt), $signed(tgt));
            end
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // motor_number, motor_count, current_pos, aim_pos, max_step,
    // arrive_threshold, max_pos, min_pos, accel, min_speed, zone_factor
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    // group_sel
    logic [IN_TUSER_W-1:0]   s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // target_pos
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    // status
    logic [OUT_TUSER_W-1:0]  m_axis_tuser;

    step_ramp_scoreboard     sb = new();
    int                      cycles = 0;
    int                      items_sent = 0;
    int                      hold_len = 0;
    bit                      tx_idle_on = 1'b1;
    bit                      rx_idle_on = 1'b1;

    axis_position_step_ramp dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("axis_position_step_ramp: mismatch");
            $finish;
        end
    end

    // Output monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
    end

    // Mostly short gaps, a few long ones, none while idling is switched off.
    function automatic int idle_len(bit on);
        int r;
        r = $urandom_range(0, 99);
        if (!on || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        int k;
        forever begin
            @(posedge i_clk);
            k = (hold_len > 0) ? hold_len : idle_len(rx_idle_on);
            hold_len = 0;
            if (k > 0) begin
                m_axis_tready <= 1'b0;
                repeat (k) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    function automatic t_item mk(int g, int mn, int mc, int cur, int aim, int ms, int thr,
                                 int pmax, int pmin, int acc, int mspd, int zone);
        t_item it;
        it.group_sel        = 1'(g);
        it.motor_number     = MNUM_W'(mn);
        it.motor_count      = MNUM_W'(mc);
        it.current_pos      = cur;
        it.aim_pos          = aim;
        it.max_step         = SPEED_W'(ms);
        it.arrive_threshold = SPEED_W'(thr);
        it.max_pos          = pmax;
        it.min_pos          = pmin;
        it.accel            = SPEED_W'(acc);
        it.min_speed        = SPEED_W'(mspd);
        it.zone_factor      = ZONE_W'(zone);
        return it;
    endfunction

    // Offer one beat, wait for its handshake, then an optional gap.
    task automatic drive_tick(input t_item it, output logic [STAT_W-1:0] st,
                              output logic signed [POS_W-1:0] tgt);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.group_sel;
        s_axis_tdata  <= {it.zone_factor, it.min_speed, it.accel, it.min_pos, it.max_pos,
                          it.arrive_threshold, it.max_step, it.aim_pos, it.current_pos,
                          it.motor_count, it.motor_number};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_tick(it, st, tgt);
        items_sent++;
        gap = idle_len(tx_idle_on);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_noise();
        t_item             it;
        logic [STAT_W-1:0] st;
        logic [POS_W-1:0]  tgt;
        it = mk($urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom, $urandom, $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom, $urandom, $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(1, 255));
        drive_tick(it, st, tgt);
    endtask

    // One closed-loop move of a single axis towards its aim.
    task automatic run_move();
        t_item             it;
        logic [STAT_W-1:0] st;
        logic [POS_W-1:0]  tgt;
        int                ms, mspd, zone, span, lo_thr;
        int                ticks;
        ms   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 2000);
        mspd = $urandom_range(0, ms);
        zone = $urandom_range(1, 20);
        lo_thr = mspd / 2 + 1;
        it = mk($urandom_range(0, 1), 0, 0, $urandom, 0, ms, 0,
                32'h7fff_ffff, 32'h8000_0000, $urandom_range(1, ms), mspd, zone);
        it.motor_count      = MNUM_W'($urandom_range(1, 15));
        it.motor_number     = MNUM_W'($urandom_range(1, it.motor_count));
        it.arrive_threshold = SPEED_W'($urandom_range(lo_thr,
                                  (lo_thr + mspd > 65535) ? 65535 : lo_thr + mspd));
        span = $urandom_range(0, ms * zone * 3);
        it.aim_pos = $urandom_range(0, 1) ? it.current_pos + span : it.current_pos - span;
        if ($urandom_range(0, 4) == 0) begin
            it.max_pos = it.current_pos + $urandom_range(0, span);
            it.min_pos = it.current_pos - $urandom_range(0, span);
        end
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        ticks = 0;
        while (ticks < 40 && items_sent < ITEM_TARGET) begin
            drive_tick(it, st, tgt);
            ticks++;
            if (st != STAT_MOVING)
                break;
            it.current_pos = tgt;
            if ($urandom_range(0, 14) == 0)
                send_noise();
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Stimulus and end of run.
    initial begin
        t_item             dir_q[$];
        logic [STAT_W-1:0] st;
        logic [POS_W-1:0]  tgt;
        bit                held, paused;
        held   = 1'b0;
        paused = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Invalid motor numbers: zero, beyond the count, empty group.
        dir_q.push_back(mk(0, 0, 8, 0, 1000, 100, 0, 32'h7fffffff, 32'h80000000, 10, 5, 4));
        dir_q.push_back(mk(1, 9, 8, 0, 1000, 100, 0, 32'h7fffffff, 32'h80000000, 10, 5, 4));
        dir_q.push_back(mk(0, 1, 0, 0, 1000, 100, 0, 32'h7fffffff, 32'h80000000, 10, 5, 4));
        // Index wrap: group 1 motor 15 shares its entry with group 0 motor 7.
        dir_q.push_back(mk(1, 15, 15, 0, 1000000, 1000, 10, 32'h7fffffff, 32'h80000000,
                           300, 50, 10));
        dir_q.push_back(mk(0, 7, 8, 300, 1000000, 1000, 10, 32'h7fffffff, 32'h80000000,
                           300, 50, 10));
        // Arrival edge: exactly 1.2 thresholds away still moves, closer arrives.
        dir_q.push_back(mk(0, 1, 8, 0, 6, 10, 5, 32'h7fffffff, 32'h80000000, 2, 3, 4));
        dir_q.push_back(mk(0, 1, 8, 0, 5, 10, 5, 32'h7fffffff, 32'h80000000, 2, 3, 4));
        // Zero difference with no threshold steps downwards.
        dir_q.push_back(mk(0, 2, 8, 100, 100, 20, 0, 32'h7fffffff, 32'h80000000, 2, 7, 4));
        dir_q.push_back(mk(0, 2, 8, 100, 100, 0, 0, 32'h7fffffff, 32'h80000000, 2, 7, 4));
        // Field extremes in both directions.
        dir_q.push_back(mk(1, 1, 15, 32'h80000000, 32'h7fffffff, 65535, 65535,
                           32'h7fffffff, 32'h80000000, 65535, 65535, 255));
        dir_q.push_back(mk(1, 1, 15, 32'h7fffffff, 32'h80000000, 65535, 65535,
                           32'h7fffffff, 32'h80000000, 65535, 65535, 255));
        // Clamping to the upper and lower travel limits.
        dir_q.push_back(mk(0, 3, 8, 1000, 100000, 500, 0, 1200, -5000, 400, 50, 10));
        dir_q.push_back(mk(0, 4, 8, -1000, -100000, 500, 0, 5000, -1200, 400, 50, 10));
        // Crossed limits: the upper limit wins.
        dir_q.push_back(mk(0, 5, 8, 0, 100000, 500, 0, -5000, 5000, 400, 50, 10));
        // Deceleration zone, then its floor, then min speed above max step.
        dir_q.push_back(mk(0, 3, 8, 0, 3000, 500, 0, 32'h7fffffff, 32'h80000000,
                           100, 50, 10));
        dir_q.push_back(mk(0, 3, 8, 0, 3000, 500, 0, 32'h7fffffff, 32'h80000000,
                           65535, 40, 10));
        dir_q.push_back(mk(0, 3, 8, 0, 300, 500, 0, 32'h7fffffff, 32'h80000000,
                           100, 900, 10));
        // Steps that leave the 32-bit range before clamping.
        dir_q.push_back(mk(0, 6, 8, 32'h7ffffff6, 32'h7fffffff, 65535, 0,
                           32'h7fffffff, 32'h80000000, 1, 1000, 1));
        dir_q.push_back(mk(0, 6, 8, 32'h8000000a, 32'h80000000, 65535, 0,
                           32'h7fffffff, 32'h80000000, 1, 1000, 1));
        foreach (dir_q[i])
            drive_tick(dir_q[i], st, tgt);

        // Random moves mixed with noise.
        while (items_sent < ITEM_TARGET) begin
            if (!held && items_sent > 150) begin
                held = 1'b1;
                hold_len = HOLD_CYCLES;
            end
            if (!paused && items_sent > 300) begin
                // Withdraw the last beat before waiting, so it is not taken twice.
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
            if ($urandom_range(0, 99) < 12)
                send_noise();
            else
                run_move();
        end
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("axis_position_step_ramp: match");
        else
            $display("axis_position_step_ramp: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
